FILE: sv/i2cm_pkg.sv
// Types and constants shared by the I2C master bit engine modules.
package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_PROBE = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_WRITE = 3'd2,
        PH_STOP  = 3'd3,
        PH_READ  = 3'd4
    } t_phase;

    typedef enum logic [0:0] {
        REG_HALF_PERIOD = 1'b0,
        REG_ACK_LIMIT   = 1'b1
    } t_reg_idx;

    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd3;
    localparam logic [15:0] ACK_LIMIT_RESET   = 16'd10000;
    localparam int          CFG_DATA_W        = 16;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_data;
        logic       send_ack;
        logic [6:0] dev_addr;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_timeout;
        logic       dev_present;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  sub_step;
        logic [3:0]  bit_count;
        logic [7:0]  shift_reg;
        logic [7:0]  half_timer;
        logic [15:0] poll_count;
        logic        probe_mode;
        logic        ack_choice;
        logic        scl;
        logic        sda;
        logic        sda_oe;
        logic [1:0]  status_flags;
        logic [7:0]  rx_byte;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:        PH_IDLE,
        sub_step:     3'd0,
        bit_count:    4'd0,
        shift_reg:    8'd0,
        half_timer:   8'd0,
        poll_count:   16'd0,
        probe_mode:   1'b0,
        ack_choice:   1'b0,
        scl:          1'b1,
        sda:          1'b1,
        sda_oe:       1'b1,
        status_flags: 2'd0,
        rx_byte:      8'd0
    };

endpackage

FILE: sv/i2cm_step.sv
// Next-state and result logic for one tick of the I2C master bit engine.
module i2cm_step import i2cm_pkg::*; (
    input  t_state    i_state,
    input  t_in_item  i_item,
    input  logic [7:0]  i_half_period,
    input  logic [15:0] i_ack_limit,
    output t_state    o_state,
    output t_out_item o_result
);

    t_state n;
    logic   done;

    always_comb begin
        logic [3:0] bc_inc;
        n      = i_state;
        done   = 1'b0;
        bc_inc = 4'd0;

        if (i_state.phase == PH_IDLE) begin
            case (i_item.cmd)
                CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_PROBE: begin
                    n.sub_step   = 3'd0;
                    n.half_timer = 8'd0;
                    n.bit_count  = 4'd0;
                    n.probe_mode = 1'b0;
                end
                default: ;
            endcase
            case (i_item.cmd)
                CMD_START: n.phase = PH_START;
                CMD_STOP:  n.phase = PH_STOP;
                CMD_WRITE: begin
                    n.phase     = PH_WRITE;
                    n.shift_reg = i_item.write_data;
                end
                CMD_READ: begin
                    n.phase      = PH_READ;
                    n.ack_choice = i_item.send_ack;
                    n.shift_reg  = 8'd0;
                end
                CMD_PROBE: begin
                    n.phase      = PH_START;
                    n.probe_mode = 1'b1;
                    n.shift_reg  = {i_item.dev_addr, 1'b0};
                end
                default: ;
            endcase
        end

        if (n.phase != PH_IDLE) begin
            if (n.half_timer != 8'd0) begin
                n.half_timer = n.half_timer - 8'd1;
            end else begin
                case (n.phase)
                    PH_START: begin
                        case (n.sub_step)
                            3'd0: begin
                                n.sda_oe = 1'b1; n.sda = 1'b1; n.scl = 1'b1;
                                n.half_timer = i_half_period; n.sub_step = 3'd1;
                            end
                            3'd1: begin
                                n.sda = 1'b0;
                                n.half_timer = i_half_period; n.sub_step = 3'd2;
                            end
                            3'd2: begin
                                n.scl = 1'b0;
                                n.half_timer = i_half_period; n.sub_step = 3'd3;
                            end
                            default: begin
                                if (n.probe_mode) begin
                                    n.phase = PH_WRITE; n.sub_step = 3'd0;
                                    n.bit_count = 4'd0;
                                end else begin
                                    n.phase = PH_IDLE; n.sub_step = 3'd0;
                                    n.half_timer = 8'd0; done = 1'b1;
                                end
                            end
                        endcase
                    end
                    PH_STOP: begin
                        case (n.sub_step)
                            3'd0: begin
                                n.sda_oe = 1'b1; n.scl = 1'b0; n.sda = 1'b0;
                                n.half_timer = i_half_period; n.sub_step = 3'd1;
                            end
                            3'd1: begin
                                n.scl = 1'b1;
                                n.half_timer = i_half_period; n.sub_step = 3'd2;
                            end
                            default: begin
                                n.sda = 1'b1;
                                if (n.probe_mode) begin
                                    n.probe_mode = 1'b0; n.sub_step = 3'd0;
                                end else begin
                                    n.phase = PH_IDLE; n.sub_step = 3'd0;
                                    n.half_timer = 8'd0; done = 1'b1;
                                end
                            end
                        endcase
                    end
                    PH_WRITE: begin
                        case (n.sub_step)
                            3'd0: begin
                                n.sda_oe = 1'b1; n.scl = 1'b0;
                                n.sda = n.shift_reg[7];
                                n.shift_reg = {n.shift_reg[6:0], 1'b0};
                                n.half_timer = i_half_period; n.sub_step = 3'd1;
                            end
                            3'd1: begin
                                n.scl = 1'b1; n.half_timer = i_half_period;
                                bc_inc = n.bit_count + 4'd1;
                                n.bit_count = bc_inc;
                                n.sub_step = (bc_inc < 4'd8) ? 3'd0 : 3'd2;
                            end
                            3'd2: begin
                                n.scl = 1'b0; n.sda_oe = 1'b0; n.sda = 1'b1;
                                n.half_timer = i_half_period; n.sub_step = 3'd3;
                            end
                            3'd3: begin
                                n.scl = 1'b1; n.poll_count = 16'd0;
                                n.half_timer = 8'd0; n.sub_step = 3'd4;
                            end
                            default: begin
                                if (!i_item.sda_in) begin
                                    n.scl = 1'b0;
                                    n.status_flags[0] = 1'b0;
                                    if (n.probe_mode) begin
                                        n.status_flags[1] = 1'b1;
                                        n.probe_mode = 1'b0;
                                        n.phase = PH_STOP; n.sub_step = 3'd0;
                                    end else begin
                                        n.phase = PH_IDLE; n.sub_step = 3'd0;
                                        n.half_timer = 8'd0; done = 1'b1;
                                    end
                                end else if (n.poll_count >= i_ack_limit) begin
                                    n.status_flags[0] = 1'b1;
                                    if (n.probe_mode) begin
                                        n.status_flags[1] = 1'b0;
                                    end
                                    n.phase = PH_STOP; n.sub_step = 3'd0;
                                end else begin
                                    n.poll_count = n.poll_count + 16'd1;
                                end
                            end
                        endcase
                    end
                    PH_READ: begin
                        case (n.sub_step)
                            3'd0: begin
                                n.scl = 1'b0; n.sda_oe = 1'b0; n.sda = 1'b1;
                                n.half_timer = i_half_period; n.sub_step = 3'd1;
                            end
                            3'd1: begin
                                n.scl = 1'b1;
                                n.half_timer = i_half_period; n.sub_step = 3'd2;
                            end
                            3'd2: begin
                                n.shift_reg = {n.shift_reg[6:0], i_item.sda_in};
                                bc_inc = n.bit_count + 4'd1;
                                n.bit_count = bc_inc;
                                n.scl = 1'b0;
                                n.half_timer = i_half_period;
                                if (bc_inc < 4'd8) begin
                                    n.sub_step = 3'd1;
                                end else begin
                                    n.sda = ~n.ack_choice; n.sda_oe = 1'b1;
                                    n.sub_step = 3'd3;
                                end
                            end
                            3'd3: begin
                                n.scl = 1'b1;
                                n.half_timer = i_half_period; n.sub_step = 3'd4;
                            end
                            default: begin
                                n.scl = 1'b0; n.rx_byte = n.shift_reg;
                                n.phase = PH_IDLE; n.sub_step = 3'd0;
                                n.half_timer = 8'd0; done = 1'b1;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_state = n;

    always_comb begin
        o_result.scl_level   = n.scl;
        o_result.sda_level   = n.sda;
        o_result.sda_drive   = n.sda_oe;
        o_result.busy_res    = (n.phase != PH_IDLE);
        o_result.done_res    = done;
        o_result.read_data   = n.rx_byte;
        o_result.ack_timeout = n.status_flags[0];
        o_result.dev_present = n.status_flags[1];
    end

endmodule

FILE: sv/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: input register, engine state and result register.
// Each input beat is one timing tick of the bus engine and yields exactly one result beat.
// The engine takes one beat per clock cycle while the output is not stalled. A beat is held
// in the input register and its result is loaded into the result register once that is free,
// so the result beat follows the input register. The rate is set by the combinational update
// of the sequencer state between the two registers. Commands are only honoured while the
// engine is idle; configuration writes take effect on the next tick.
module i2c_master_bit_engine_top import i2cm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic        r_in_valid;
    t_in_item    r_in_data;
    logic        r_out_valid;
    t_out_item   r_out_data;
    t_state      r_st;
    t_state      n_st;
    t_out_item   n_out;
    logic [7:0]  r_half;
    logic [15:0] r_limit;
    logic        w_advance;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    i2cm_step u_step (
        .i_state       (r_st),
        .i_item        (r_in_data),
        .i_half_period (r_half),
        .i_ack_limit   (r_limit),
        .o_state       (n_st),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_st        <= STATE_RESET;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
            r_st        <= n_st;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance) begin
            r_out_data <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= HALF_PERIOD_RESET;
            r_limit <= ACK_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_HALF_PERIOD: r_half  <= i_cfg_wdata[7:0];
                REG_ACK_LIMIT:   r_limit <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: sv/i2cm_checker.sv
// Port-level checks for the I2C master bit engine and their binding to the top level.
module i2cm_checker import i2cm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready without an output stall");

    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.sda_drive || o_out_data.sda_level)
        else $error("SDA level low while released");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("done reported while still busy");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: test/i2c_master_bit_engine_top_test.sv
// Self-checking testbench for the I2C master bit engine: random bus ticks against a tick model.
module i2c_master_bit_engine_top_test;
    import i2cm_pkg::*;

    localparam int         LIMIT_CYCLES = 20000;
    localparam logic [2:0] CMD_RSVD6    = 3'd6;
    localparam logic [2:0] CMD_RSVD7    = 3'd7;

    typedef enum int {
        SDA_RANDOM,
        SDA_HIGH,
        SDA_LOW
    } t_sda_mode;

    typedef struct {
        t_phase      phase;
        logic [2:0]  step;
        logic [3:0]  bits;
        logic [7:0]  shifter;
        logic [7:0]  timer;
        logic [15:0] polls;
        logic        probing;
        logic        ack_bit;
        logic        scl;
        logic        sda;
        logic        sda_oe;
        logic [1:0]  flags;
        logic [7:0]  rx;
    } t_engine;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    t_in_item              in_data     = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we      = 1'b0;
    logic [0:0]            cfg_idx     = REG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

    t_engine     eng;
    logic [7:0]  half_ticks;
    logic [15:0] ack_limit;
    t_in_item    bus_ticks[$];
    t_out_item   expected_pins[$];
    t_out_item   predicted;
    t_out_item   oldest;
    bit          in_taken    = 1'b0;
    int          gap_pct     = 0;
    int          stall_pct   = 0;
    int          hold_cycles = 0;
    int          errors      = 0;
    int          cycle       = 0;
    int          queued      = 0;
    int          accepted    = 0;

    i2c_master_bit_engine_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    task automatic advance_engine(input t_in_item tk, output t_out_item res);
        logic done;
        done = 1'b0;
        if (eng.phase == PH_IDLE && tk.cmd >= CMD_START && tk.cmd <= CMD_PROBE) begin
            eng.step    = 3'd0;
            eng.timer   = 8'd0;
            eng.bits    = 4'd0;
            eng.probing = 1'b0;
            case (tk.cmd)
                CMD_START: begin
                    eng.phase = PH_START;
                end
                CMD_STOP: begin
                    eng.phase = PH_STOP;
                end
                CMD_WRITE: begin
                    eng.phase   = PH_WRITE;
                    eng.shifter = tk.write_data;
                end
                CMD_READ: begin
                    eng.phase   = PH_READ;
                    eng.ack_bit = tk.send_ack;
                    eng.shifter = 8'd0;
                end
                default: begin
                    eng.phase   = PH_START;
                    eng.probing = 1'b1;
                    eng.shifter = {tk.dev_addr, 1'b0};
                end
            endcase
        end

        if (eng.phase != PH_IDLE) begin
            if (eng.timer != 8'd0) begin
                eng.timer = eng.timer - 8'd1;
            end else begin
                case (eng.phase)
                    PH_START: begin
                        case (eng.step)
                            3'd0: begin
                                eng.sda_oe = 1'b1;
                                eng.sda    = 1'b1;
                                eng.scl    = 1'b1;
                                eng.timer  = half_ticks;
                                eng.step   = 3'd1;
                            end
                            3'd1: begin
                                eng.sda   = 1'b0;
                                eng.timer = half_ticks;
                                eng.step  = 3'd2;
                            end
                            3'd2: begin
                                eng.scl   = 1'b0;
                                eng.timer = half_ticks;
                                eng.step  = 3'd3;
                            end
                            default: begin
                                if (eng.probing) begin
                                    eng.phase = PH_WRITE;
                                    eng.step  = 3'd0;
                                    eng.bits  = 4'd0;
                                end else begin
                                    eng.phase = PH_IDLE;
                                    eng.step  = 3'd0;
                                    eng.timer = 8'd0;
                                    done      = 1'b1;
                                end
                            end
                        endcase
                    end
                    PH_STOP: begin
                        case (eng.step)
                            3'd0: begin
                                eng.sda_oe = 1'b1;
                                eng.scl    = 1'b0;
                                eng.sda    = 1'b0;
                                eng.timer  = half_ticks;
                                eng.step   = 3'd1;
                            end
                            3'd1: begin
                                eng.scl   = 1'b1;
                                eng.timer = half_ticks;
                                eng.step  = 3'd2;
                            end
                            default: begin
                                eng.sda = 1'b1;
                                if (eng.probing) begin
                                    eng.probing = 1'b0;
                                    eng.step    = 3'd0;
                                end else begin
                                    eng.phase = PH_IDLE;
                                    eng.step  = 3'd0;
                                    eng.timer = 8'd0;
                                    done      = 1'b1;
                                end
                            end
                        endcase
                    end
                    PH_WRITE: begin
                        case (eng.step)
                            3'd0: begin
                                eng.sda_oe  = 1'b1;
                                eng.scl     = 1'b0;
                                eng.sda     = eng.shifter[7];
                                eng.shifter = {eng.shifter[6:0], 1'b0};
                                eng.timer   = half_ticks;
                                eng.step    = 3'd1;
                            end
                            3'd1: begin
                                eng.scl   = 1'b1;
                                eng.timer = half_ticks;
                                eng.bits  = eng.bits + 4'd1;
                                eng.step  = (eng.bits < 4'd8) ? 3'd0 : 3'd2;
                            end
                            3'd2: begin
                                eng.scl    = 1'b0;
                                eng.sda_oe = 1'b0;
                                eng.sda    = 1'b1;
                                eng.timer  = half_ticks;
                                eng.step   = 3'd3;
                            end
                            3'd3: begin
                                eng.scl   = 1'b1;
                                eng.polls = 16'd0;
                                eng.timer = 8'd0;
                                eng.step  = 3'd4;
                            end
                            default: begin
                                if (!tk.sda_in) begin
                                    eng.scl      = 1'b0;
                                    eng.flags[0] = 1'b0;
                                    if (eng.probing) begin
                                        eng.flags[1] = 1'b1;
                                        eng.probing  = 1'b0;
                                        eng.phase    = PH_STOP;
                                        eng.step     = 3'd0;
                                    end else begin
                                        eng.phase = PH_IDLE;
                                        eng.step  = 3'd0;
                                        eng.timer = 8'd0;
                                        done      = 1'b1;
                                    end
                                end else if (eng.polls >= ack_limit) begin
                                    eng.flags[0] = 1'b1;
                                    if (eng.probing) begin
                                        eng.flags[1] = 1'b0;
                                    end
                                    eng.phase = PH_STOP;
                                    eng.step  = 3'd0;
                                end else begin
                                    eng.polls = eng.polls + 16'd1;
                                end
                            end
                        endcase
                    end
                    default: begin
                        case (eng.step)
                            3'd0: begin
                                eng.scl    = 1'b0;
                                eng.sda_oe = 1'b0;
                                eng.sda    = 1'b1;
                                eng.timer  = half_ticks;
                                eng.step   = 3'd1;
                            end
                            3'd1: begin
                                eng.scl   = 1'b1;
                                eng.timer = half_ticks;
                                eng.step  = 3'd2;
                            end
                            3'd2: begin
                                eng.shifter = {eng.shifter[6:0], tk.sda_in};
                                eng.bits    = eng.bits + 4'd1;
                                eng.scl     = 1'b0;
                                eng.timer   = half_ticks;
                                if (eng.bits < 4'd8) begin
                                    eng.step = 3'd1;
                                end else begin
                                    eng.sda    = ~eng.ack_bit;
                                    eng.sda_oe = 1'b1;
                                    eng.step   = 3'd3;
                                end
                            end
                            3'd3: begin
                                eng.scl   = 1'b1;
                                eng.timer = half_ticks;
                                eng.step  = 3'd4;
                            end
                            default: begin
                                eng.scl   = 1'b0;
                                eng.rx    = eng.shifter;
                                eng.phase = PH_IDLE;
                                eng.step  = 3'd0;
                                eng.timer = 8'd0;
                                done      = 1'b1;
                            end
                        endcase
                    end
                endcase
            end
        end

        res.scl_level   = eng.scl;
        res.sda_level   = eng.sda;
        res.sda_drive   = eng.sda_oe;
        res.busy_res    = (eng.phase != PH_IDLE);
        res.done_res    = done;
        res.read_data   = eng.rx;
        res.ack_timeout = eng.flags[0];
        res.dev_present = eng.flags[1];
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    function automatic logic sda_level_for(input t_sda_mode mode);
        if (mode == SDA_HIGH) begin
            return 1'b1;
        end else if (mode == SDA_LOW) begin
            return 1'b0;
        end
        return logic'($urandom_range(0, 1));
    endfunction

    // A command beat is followed by enough filler beats for the command to finish, unless cut short.
    task automatic queue_command(input logic [2:0] cmd, input logic [7:0] wdata, input logic sack,
                                 input logic [6:0] addr, input t_sda_mode mode, input bit cut,
                                 input bit noisy);
        int       fill;
        int       ticks;
        t_in_item tk;
        ticks = int'(half_ticks) + 1;
        case (cmd)
            CMD_START: fill = 3 * ticks + 2;
            CMD_STOP:  fill = 2 * ticks + 2;
            CMD_WRITE: fill = 17 * ticks + 3;
            CMD_READ:  fill = 18 * ticks + 2;
            CMD_PROBE: fill = 22 * ticks + 5;
            default:   fill = 1;
        endcase
        if (mode == SDA_HIGH && (cmd == CMD_WRITE || cmd == CMD_PROBE)) begin
            fill = fill + int'(ack_limit) + 4 + 4 * ticks;
        end
        fill = fill + $urandom_range(0, 3);
        if (cut) begin
            fill = $urandom_range(1, (fill + 1) / 2);
        end
        tk.cmd        = cmd;
        tk.write_data = wdata;
        tk.send_ack   = sack;
        tk.dev_addr   = addr;
        tk.sda_in     = sda_level_for(mode);
        bus_ticks.push_back(tk);
        queued++;
        repeat (fill) begin
            tk.cmd        = (noisy && $urandom_range(0, 99) < 8) ? 3'($urandom_range(0, 7)) : CMD_NONE;
            tk.write_data = 8'($urandom);
            tk.send_ack   = 1'($urandom);
            tk.dev_addr   = 7'($urandom);
            tk.sda_in     = sda_level_for(mode);
            bus_ticks.push_back(tk);
            queued++;
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        if (idx == REG_HALF_PERIOD) begin
            half_ticks = val[7:0];
        end else begin
            ack_limit = val;
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (!(accepted == queued && expected_pins.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(input int hp, input int lim, input int n, input int nak_pct,
                             input int gap, input int stall, input int hold);
        int         r;
        int         m;
        logic [2:0] cmd;
        t_sda_mode  mode;
        wait_drained();
        write_reg(REG_HALF_PERIOD, 16'(hp));
        write_reg(REG_ACK_LIMIT, 16'(lim));
        gap_pct     = gap;
        stall_pct   = stall;
        hold_cycles = hold;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                cmd = CMD_NONE;
            end else if (r < 6) begin
                cmd = CMD_RSVD6;
            end else if (r < 8) begin
                cmd = CMD_RSVD7;
            end else begin
                cmd = 3'($urandom_range(1, 5));
            end
            m = $urandom_range(0, 99);
            if (m < nak_pct) begin
                mode = SDA_HIGH;
            end else if (m < nak_pct + 15) begin
                mode = SDA_LOW;
            end else begin
                mode = SDA_RANDOM;
            end
            queue_command(cmd, 8'($urandom), 1'($urandom), 7'($urandom), mode,
                          $urandom_range(0, 99) < 12, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        cycle++;
        if (cycle >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && in_ready) begin
            advance_engine(in_data, predicted);
            expected_pins.push_back(predicted);
            accepted++;
            in_taken = 1'b1;
        end
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_pins.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
            end else begin
                oldest = expected_pins.pop_front();
                check_field("scl_level", 8'(oldest.scl_level), 8'(out_data.scl_level));
                check_field("sda_level", 8'(oldest.sda_level), 8'(out_data.sda_level));
                check_field("sda_drive", 8'(oldest.sda_drive), 8'(out_data.sda_drive));
                check_field("busy_res", 8'(oldest.busy_res), 8'(out_data.busy_res));
                check_field("done_res", 8'(oldest.done_res), 8'(out_data.done_res));
                check_field("read_data", oldest.read_data, out_data.read_data);
                check_field("ack_timeout", 8'(oldest.ack_timeout), 8'(out_data.ack_timeout));
                check_field("dev_present", 8'(oldest.dev_present), 8'(out_data.dev_present));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            in_taken = 1'b0;
            if (bus_ticks.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                in_data  <= bus_ticks.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles--;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        eng = '{PH_IDLE, 3'd0, 4'd0, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0,
                1'b1, 1'b1, 1'b1, 2'd0, 8'd0};
        half_ticks = HALF_PERIOD_RESET;
        ack_limit  = ACK_LIMIT_RESET;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: an acknowledged probe, unused codes and a read cut short.
        queue_command(CMD_PROBE, 8'h00, 1'b0, 7'h2A, SDA_LOW, 1'b0, 1'b0);
        queue_command(CMD_RSVD6, 8'hFF, 1'b1, 7'h7F, SDA_RANDOM, 1'b0, 1'b0);
        queue_command(CMD_RSVD7, 8'hFF, 1'b1, 7'h7F, SDA_RANDOM, 1'b0, 1'b0);
        queue_command(CMD_NONE, 8'hFF, 1'b1, 7'h7F, SDA_RANDOM, 1'b0, 1'b0);
        queue_command(CMD_READ, 8'h00, 1'b1, 7'h00, SDA_RANDOM, 1'b1, 1'b0);

        // Zero half period and zero limit: timeouts on the first high poll, acked commands, start, stop.
        wait_drained();
        write_reg(REG_HALF_PERIOD, 16'h0000);
        write_reg(REG_ACK_LIMIT, 16'h0000);
        queue_command(CMD_WRITE, 8'hFF, 1'b0, 7'h00, SDA_HIGH, 1'b0, 1'b0);
        queue_command(CMD_PROBE, 8'h00, 1'b0, 7'h7F, SDA_HIGH, 1'b0, 1'b0);
        queue_command(CMD_PROBE, 8'h00, 1'b0, 7'h00, SDA_LOW, 1'b0, 1'b0);
        queue_command(CMD_WRITE, 8'h00, 1'b0, 7'h00, SDA_LOW, 1'b0, 1'b0);
        queue_command(CMD_READ, 8'h00, 1'b0, 7'h00, SDA_LOW, 1'b0, 1'b0);
        queue_command(CMD_START, 8'h00, 1'b0, 7'h00, SDA_RANDOM, 1'b0, 1'b0);
        queue_command(CMD_STOP, 8'h00, 1'b0, 7'h00, SDA_RANDOM, 1'b0, 1'b0);

        run_phase(0, 2, 3, 20, 0, 0, 100);
        run_phase(1, 1, 2, 20, 64, 0, 0);
        run_phase(0, 3, 3, 15, 0, 64, 0);
        run_phase(0, 1, 3, 20, 21, 21, 0);

        wait_drained();
        repeat (4) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
